>>> design/stdp_pkg.sv
// shared types and constants for the stereo dither to pcm16 block
`timescale 1ns / 1ps
`default_nettype none
package stdp_pkg;

  localparam int unsigned MIX_W        = 40;
  localparam int unsigned PCM_W        = 16;
  localparam int unsigned SEED_W       = 32;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [SEED_W-1:0] LCG_MUL        = 32'd134775813;
  localparam logic [SEED_W-1:0] LCG_SEED_RESET = 32'h1234_5000;

  // input word: one stereo frame of mixed audio
  typedef struct packed {
    logic signed [MIX_W-1:0] left_mix;
    logic signed [MIX_W-1:0] right_mix;
    logic                    last_frame;
  } mix_word_t;

  // output word: one 16-bit stereo frame
  typedef struct packed {
    logic signed [PCM_W-1:0] left_pcm;
    logic signed [PCM_W-1:0] right_pcm;
    logic                    last_out;
  } pcm_word_t;

  // queue fill status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

>>> design/stereo_tpdf_dither_to_pcm16.sv
// Stereo TPDF dither and conversion of mixed audio to 16-bit PCM.
//
// mix channel: one stereo frame per word (40-bit signed samples with 16
// fraction bits plus a last-frame mark), taken when mix_valid is high and
// mix_stall is low. pcm channel: one 16-bit stereo frame per input word,
// held in an output register until pcm_valid is high and pcm_stall is low.
// The single lcg multiplier in the back stage steps the generator once for
// left and once for right, and the back stage takes the next frame from the
// queue as it loads a finished frame into the output register.
// A front register and a short queue decouple the input from the back stage,
// so input words keep flowing while a finished frame waits at the output.
// When pcm_stall is held the back stage keeps its finished frame, the queue
// fills and mix_stall then rises.
// Reset (rst, synchronous) empties the front register, queue and output
// register, loads the generator seed with 0x12345000 and clears the
// previous dither of both channels.
`timescale 1ns / 1ps
`default_nettype none
module stereo_tpdf_dither_to_pcm16
  import stdp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      mix_valid,
  output logic           mix_stall,
  input  wire mix_word_t mix,
  output logic           pcm_valid,
  input  wire logic      pcm_stall,
  output pcm_word_t      pcm
);

  q_stat_t   qstat;
  logic      push;
  logic      pop;
  mix_word_t push_word;
  mix_word_t head;

  stdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mix_valid (mix_valid),
    .mix_stall (mix_stall),
    .mix       (mix),
    .qstat     (qstat),
    .push      (push),
    .push_word (push_word)
  );

  stdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  stdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .pcm_valid (pcm_valid),
    .pcm_stall (pcm_stall),
    .pcm       (pcm)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    mix_stall |-> qstat.full && !qstat.empty)
    else $error("input stalled without a full queue");
`endif

endmodule
`default_nettype wire

>>> design/stdp_front.sv
// front stage: takes input words and hands them to the queue
`timescale 1ns / 1ps
`default_nettype none
module stdp_front
  import stdp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      mix_valid,
  output logic           mix_stall,
  input  wire mix_word_t mix,
  input  wire q_stat_t   qstat,
  output logic           push,
  output mix_word_t      push_word
);

  logic      hold_valid;
  mix_word_t hold;
  logic      accept;

  assign mix_stall = hold_valid && qstat.full;
  assign push      = hold_valid && !qstat.full;
  assign accept    = mix_valid && !mix_stall;
  assign push_word = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (push) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= mix;
    end
  end

endmodule
`default_nettype wire

>>> design/stdp_queue.sv
// short word queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module stdp_queue
  import stdp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire mix_word_t push_word,
  input  wire logic      pop,
  output mix_word_t      head,
  output q_stat_t        qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mix_word_t          entry [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head        = entry[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

endmodule
`default_nettype wire

>>> design/stdp_back.sv
// back stage: lcg steps, dither, truncation, saturation and output register
`timescale 1ns / 1ps
`default_nettype none
module stdp_back
  import stdp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire mix_word_t head,
  input  wire q_stat_t   qstat,
  output logic           pop,
  output logic           pcm_valid,
  input  wire logic      pcm_stall,
  output pcm_word_t      pcm
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEFT,
    ST_RIGHT
  } state_t;

  localparam int unsigned SUM_W = MIX_W + 2;
  localparam int unsigned Q_W   = SUM_W - FRAC_W;

  // sample + new dither - old dither, truncated toward zero, saturated
  function automatic logic signed [PCM_W-1:0] dither_pcm(
    input logic signed [MIX_W-1:0] smp,
    input logic signed [PCM_W-1:0] d_new,
    input logic signed [PCM_W-1:0] d_old
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [Q_W-1:0]   fl;
    logic signed [Q_W-1:0]   q;
    logic signed [PCM_W-1:0] res;
    sum = SUM_W'(smp) + SUM_W'(d_new) - SUM_W'(d_old);
    fl  = sum[SUM_W-1:FRAC_W];
    // floor shift rounds down, so step negative values with a remainder up by one
    if (sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0)) begin
      q = fl + Q_W'(1);
    end else begin
      q = fl;
    end
    if (q > Q_W'(signed'(17'sd32767))) begin
      res = {1'b0, {(PCM_W-1){1'b1}}};
    end else if (q < Q_W'(signed'(17'sh1_8000))) begin
      res = {1'b1, {(PCM_W-1){1'b0}}};
    end else begin
      res = q[PCM_W-1:0];
    end
    return res;
  endfunction

  state_t                  state;
  logic [SEED_W-1:0]       seed;
  logic [SEED_W-1:0]       seed_next;
  logic signed [PCM_W-1:0] dither;
  logic signed [PCM_W-1:0] prev_left;
  logic signed [PCM_W-1:0] prev_right;
  logic signed [PCM_W-1:0] left_res;
  mix_word_t               cur;
  logic                    out_free;
  logic                    pcm_valid_next;

  assign seed_next = seed * LCG_MUL + SEED_W'(1);
  assign dither    = seed[SEED_W-1:SEED_W-PCM_W];
  assign out_free  = !pcm_valid || !pcm_stall;
  assign pop       = !qstat.empty &&
                     ((state == ST_IDLE) || ((state == ST_RIGHT) && out_free));
  // a finished frame loads the output register, else it holds while stalled
  assign pcm_valid_next = ((state == ST_RIGHT) && out_free) || (pcm_valid && pcm_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seed       <= LCG_SEED_RESET;
      prev_left  <= '0;
      prev_right <= '0;
      pcm_valid  <= 1'b0;
    end else begin
      pcm_valid <= pcm_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            seed  <= seed_next;
            cur   <= head;
            state <= ST_LEFT;
          end
        end
        ST_LEFT: begin
          // seed holds the left dither now; step again for right
          seed      <= seed_next;
          prev_left <= dither;
          left_res  <= dither_pcm(cur.left_mix, dither, prev_left);
          state     <= ST_RIGHT;
        end
        ST_RIGHT: begin
          if (out_free) begin
            pcm.left_pcm   <= left_res;
            pcm.right_pcm  <= dither_pcm(cur.right_mix, dither, prev_right);
            pcm.last_out   <= cur.last_frame;
            prev_right     <= dither;
            if (pop) begin
              seed  <= seed_next;
              cur   <= head;
              state <= ST_LEFT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_stereo_tpdf_dither_to_pcm16.sv
// testbench for the stereo tpdf dither to pcm16 block: predicted frames checked word by word
`timescale 1ns / 1ps
module tb_stereo_tpdf_dither_to_pcm16;
  import stdp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic signed [MIX_W-1:0] MIX_MAX    = {1'b0, {(MIX_W-1){1'b1}}};
  localparam logic signed [MIX_W-1:0] MIX_MIN    = {1'b1, {(MIX_W-1){1'b0}}};
  localparam logic signed [MIX_W-1:0] ONE_LSB    = 40'sd65536;
  localparam logic signed [MIX_W-1:0] PCM_TOP    = 40'sd2147418112;
  localparam logic signed [MIX_W-1:0] PCM_BOTTOM = -40'sd2147483648;

  logic      clk;
  logic      rst;
  logic      mix_valid;
  logic      mix_stall;
  mix_word_t mix;
  logic      pcm_valid;
  logic      pcm_stall;
  pcm_word_t pcm;

  // predictor state
  logic [SEED_W-1:0]       dither_seed = LCG_SEED_RESET;
  logic signed [PCM_W-1:0] prev_dither_l = '0;
  logic signed [PCM_W-1:0] prev_dither_r = '0;
  pcm_word_t               expected_pcm[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  send_gapless = 1'b0;
  bit  take_eagerly = 1'b0;

  stereo_tpdf_dither_to_pcm16 DUT (
    .clk       (clk),
    .rst       (rst),
    .mix_valid (mix_valid),
    .mix_stall (mix_stall),
    .mix       (mix),
    .pcm_valid (pcm_valid),
    .pcm_stall (pcm_stall),
    .pcm       (pcm)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // advance the lcg and return the top half of the seed as a signed dither
  function automatic logic signed [PCM_W-1:0] next_dither();
    dither_seed = dither_seed * LCG_MUL + 32'd1;
    return dither_seed[SEED_W-1:SEED_W-PCM_W];
  endfunction

  function automatic logic signed [PCM_W-1:0] quantize(
    input logic signed [MIX_W-1:0] sample,
    input logic signed [PCM_W-1:0] d,
    input logic signed [PCM_W-1:0] prev
  );
    logic signed [MIX_W+1:0] sum;
    logic signed [MIX_W+1:0] mag;
    logic signed [MIX_W+1:0] whole;
    sum = sample;
    sum = sum + d - prev;
    // truncate toward zero
    mag = sum[MIX_W+1] ? -sum : sum;
    whole = mag >>> FRAC_W;
    if (sum[MIX_W+1])
      whole = -whole;
    if (whole > 32767)
      return 16'sh7fff;
    if (whole < -32768)
      return 16'sh8000;
    return whole[PCM_W-1:0];
  endfunction

  function automatic pcm_word_t dither_frame(input mix_word_t w);
    pcm_word_t               r;
    logic signed [PCM_W-1:0] d;
    d = next_dither();
    r.left_pcm = quantize(w.left_mix, d, prev_dither_l);
    prev_dither_l = d;
    d = next_dither();
    r.right_pcm = quantize(w.right_mix, d, prev_dither_r);
    prev_dither_r = d;
    r.last_out = w.last_frame;
    return r;
  endfunction

  function automatic logic signed [MIX_W-1:0] rand_sample();
    logic signed [MIX_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = MIX_W'({$urandom(), $urandom()});
      1: v = $signed($urandom());
      2: v = $signed($urandom()) >>> 8;
      3: begin
        v = $urandom_range(0, 2**18);
        v = v - 2**17;
      end
      4: begin
        // around the saturation edges
        case ($urandom_range(0, 3))
          0: v = PCM_TOP;
          1: v = PCM_TOP + ONE_LSB;
          2: v = PCM_BOTTOM;
          default: v = PCM_BOTTOM - ONE_LSB;
        endcase
        v = v + $urandom_range(0, 2**18) - 2**17;
      end
      default: v = $urandom_range(0, 1) ? MIX_MAX : MIX_MIN;
    endcase
    return v;
  endfunction

  // called at a falling edge; returns at a falling edge with mix_valid still high
  task automatic send_frame(
    input logic signed [MIX_W-1:0] l,
    input logic signed [MIX_W-1:0] r,
    input logic                    last
  );
    int gap;
    gap = send_gapless ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      mix_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mix.left_mix = l;
    mix.right_mix = r;
    mix.last_frame = last;
    mix_valid = 1'b1;
    @(posedge clk);
    while (mix_stall)
      @(posedge clk);
    expected_pcm.push_back(dither_frame(mix));
    @(negedge clk);
  endtask

  // result side: random stall per word, then check the accepted word
  initial begin
    int        hold;
    pcm_word_t want;
    pcm_stall = 1'b0;
    wait (!rst);
    forever begin
      hold = take_eagerly ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        pcm_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      pcm_stall = 1'b0;
      @(posedge clk);
      while (!pcm_valid)
        @(posedge clk);
      if (expected_pcm.size() == 0) begin
        report($sformatf("pcm word with nothing expected: %p", pcm));
      end else begin
        want = expected_pcm.pop_front();
        if (pcm.left_pcm !== want.left_pcm)
          report($sformatf("left_pcm got %0d, expected %0d", pcm.left_pcm, want.left_pcm));
        if (pcm.right_pcm !== want.right_pcm)
          report($sformatf("right_pcm got %0d, expected %0d", pcm.right_pcm, want.right_pcm));
        if (pcm.last_out !== want.last_out)
          report($sformatf("last_out got %b, expected %b", pcm.last_out, want.last_out));
      end
      @(negedge clk);
    end
  end

  task automatic test_corner_frames();
    send_gapless = 1'b0;
    take_eagerly = 1'b0;
    send_frame('0, '0, 1'b0);
    send_frame(MIX_MAX, MIX_MIN, 1'b0);
    send_frame(MIX_MIN, MIX_MAX, 1'b1);
    send_frame(-1, 1, 1'b0);
    send_frame(-ONE_LSB, ONE_LSB, 1'b0);
    send_frame(-ONE_LSB - 1, ONE_LSB - 1, 1'b1);
    send_frame(-ONE_LSB + 1, ONE_LSB + 1, 1'b0);
    send_frame(-3 * ONE_LSB / 2, 3 * ONE_LSB / 2, 1'b0);
    send_frame(PCM_TOP, PCM_BOTTOM, 1'b0);
    send_frame(PCM_TOP + ONE_LSB - 1, PCM_BOTTOM - ONE_LSB + 1, 1'b1);
    send_frame(PCM_TOP + ONE_LSB, PCM_BOTTOM - ONE_LSB, 1'b0);
    send_frame(PCM_BOTTOM - 1, PCM_TOP + ONE_LSB, 1'b0);
    send_frame(MIX_MAX, MIX_MAX, 1'b1);
    send_frame(MIX_MIN, MIX_MIN, 1'b0);
    send_frame(-ONE_LSB / 2, ONE_LSB / 2, 1'b1);
  endtask

  // sender holds off until every pending pcm word has come back
  task automatic test_drain_pause();
    send_gapless = 1'b1;
    take_eagerly = 1'b0;
    repeat (6)
      send_frame(rand_sample(), rand_sample(), $urandom_range(0, 1));
    mix_valid = 1'b0;
    while (expected_pcm.size() != 0)
      @(posedge clk);
    @(negedge clk);
    repeat (6)
      send_frame(rand_sample(), rand_sample(), $urandom_range(0, 1));
  endtask

  task automatic test_random_frames(input int count, input bit gapless, input bit eager);
    send_gapless = gapless;
    take_eagerly = eager;
    repeat (count)
      send_frame(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    rst = 1'b1;
    mix_valid = 1'b0;
    mix = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_frames();
    test_drain_pause();
    test_random_frames(250, 1'b0, 1'b0);
    test_random_frames(250, 1'b1, 1'b0);
    test_random_frames(250, 1'b0, 1'b1);
    test_random_frames(250, 1'b1, 1'b1);
    mix_valid = 1'b0;
    take_eagerly = 1'b1;

    while (expected_pcm.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
